// ===== hw/rtl/kepler_equation_solver_assert.svh =====
// Assertion macros for the Kepler solver checker.
`ifndef KEPLER_EQUATION_SOLVER_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_ASSERT_SVH

// Check that cond_a implies cond_b in the same cycle.
`define KES_ASSERT_SAME(lbl, clk_s, rst_s, cond_a, cond_b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond_a) |-> (cond_b)) \
    else $error("kepler solver check failed");

// Check that cond_a implies cond_b in the following cycle.
`define KES_ASSERT_NEXT(lbl, clk_s, rst_s, cond_a, cond_b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond_a) |=> (cond_b)) \
    else $error("kepler solver check failed");

`endif

// ===== hw/rtl/kes_pkg.sv =====
// Constants, formats and the CORDIC arctangent table of the Kepler solver.
package kes_pkg;

  localparam int FRAC_BITS        = 27;
  localparam int CORDIC_FRAC      = 28;
  localparam int CORDIC_STEPS     = 28;
  localparam int MAX_ITER_DEFAULT = 12;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // pi at the I/O format and at the CORDIC format, rounded to nearest
  localparam logic signed [33:0] PI_F =
    34'((PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
  localparam logic signed [33:0] TWO_PI_F = PI_F + PI_F;
  localparam logic signed [33:0] NEG_PI_F = -PI_F;
  localparam logic signed [33:0] PI_C =
    34'((PI_Q60 + (64'd1 << (59 - CORDIC_FRAC))) >> (60 - CORDIC_FRAC));
  localparam logic signed [33:0] TWO_PI_C  = PI_C + PI_C;
  localparam logic signed [33:0] NEG_PI_C  = -PI_C;
  localparam logic signed [33:0] HALF_PI_C = PI_C >>> 1;
  localparam logic signed [33:0] NEG_HALF_PI_C = -HALF_PI_C;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;
  localparam logic signed [31:0] SLOPE_FLOOR = 32'sd4096;
  localparam logic signed [31:0] ONE_C       = 32'sd1 <<< CORDIC_FRAC;
  localparam int ESIN_SHIFT = 16 + CORDIC_FRAC - FRAC_BITS;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  // Series expansion of atan(2^-i) at Q60, rounded to Q28. Elaboration only.
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] acc;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rmd;
    logic [63:0] den;
    int          sh;
    tab[0] = 32'(((PI_Q60 >> 2) + (64'd1 << 31)) >> 32);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        sh  = i * (2 * k + 1);
        num = (64'd1 << 60) >> sh;
        den = 64'(2 * k + 1);
        quo = '0;
        rmd = '0;
        for (int b = 63; b >= 0; b--) begin
          rmd = {rmd[62:0], num[b]};
          if (rmd >= den) begin
            rmd    = rmd - den;
            quo[b] = 1'b1;
          end
        end
        if ((k & 1) != 0) acc = acc - quo;
        else acc = acc + quo;
      end
      tab[i] = 32'((acc + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TABLE = build_atan();

endpackage

// ===== hw/rtl/kepler_equation_solver.sv =====
// Kepler equation solver: Newton-Raphson on M = E - e*sin(E) with a CORDIC core.
//
// Pulse start while busy is low to hand in one beat (mean_anomaly, signed
// Q4.27; eccentricity, Q0.16). busy stays high for the whole solve, and the
// answer is on eccentric_anomaly when done is high for exactly one cycle;
// capture it then. The register keeps it until the next solve's first
// update. The input angle is first wrapped into [-pi, pi] by repeated
// add/subtract of 2*pi. Each Newton step then wraps the angle for CORDIC
// and folds it into the half circle, runs the CORDIC rotations, uses the
// one shared 17x32 multiplier for e*sin, then e*cos, forms the residual
// and slope, runs the bit-serial restoring divider that sets the pace,
// and updates the estimate. A solve runs max_iterations steps (zero
// counts as one, values above MAX_ITERATIONS are capped) or stops early
// once |correction| < tolerance. Write configuration through
// cfg_valid/cfg_data only while busy is low; cfg_ready is always high.
module kepler_equation_solver #(
  parameter int MAX_ITERATIONS = kes_pkg::MAX_ITER_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               mean_anomaly,
  input  logic        [15:0]               eccentricity,
  output logic                             done,
  output logic signed [31:0]               eccentric_anomaly,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kes_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kes_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import kes_pkg::*;

  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int DIV_W  = 34 + CORDIC_FRAC;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TOL      = CFG_INDEX_W'(1);

  localparam logic signed [49:0] ESIN_HALF = 50'sd1 <<< (ESIN_SHIFT - 1);
  localparam logic signed [49:0] ECOS_HALF = 50'sd1 <<< 15;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRAPM = 9'b000000010,
    S_WRAPZ = 9'b000000100,
    S_ROT   = 9'b000001000,
    S_MULS  = 9'b000010000,
    S_MULC  = 9'b000100000,
    S_RES   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_UPD   = 9'b100000000
  } state_t;

  state_t state;

  logic [3:0]  max_iter;
  logic [15:0] tol;

  logic signed [33:0] m;
  logic signed [31:0] e_anom;
  logic signed [33:0] z;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic               neg;
  logic [15:0]        ecc;
  logic [STEP_W-1:0]  step;
  logic [ITER_W-1:0]  iter_cnt;
  logic [ITER_W-1:0]  iter_lim;
  logic signed [48:0] prod;
  logic signed [31:0] esin;
  logic [29:0]        slope;
  logic               res_neg;
  logic [DIV_W-1:0]   dvd;
  logic [29:0]        rmd;
  logic [DCNT_W-1:0]  div_cnt;

  // datapath helpers
  logic signed [31:0] mul_b;
  logic signed [48:0] mul_out;
  logic signed [31:0] ecos;
  logic signed [31:0] slope_raw;
  logic signed [34:0] res;
  logic [34:0]        res_abs;
  logic [30:0]        rmd_sh;
  logic               q_bit;
  logic signed [63:0] corr;
  logic signed [63:0] e_new;
  logic signed [31:0] e_sat;
  logic               small_corr;
  logic               last_iter;
  logic signed [33:0] atan_s;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // One shared multiplier: sine in S_MULS, cosine otherwise.
  always_comb begin
    if (state == S_MULS) mul_b = neg ? -y : y;
    else mul_b = neg ? -x : x;
    mul_out = 49'($signed({1'b0, ecc}) * mul_b);
  end

  always_comb begin
    ecos      = 32'(($signed({prod[48], prod}) + ECOS_HALF) >>> 16);
    slope_raw = ONE_C - ecos;
    res       = 35'(e_anom) - 35'(esin) - 35'(m);
    res_abs   = res[34] ? -res : res;
    rmd_sh    = {rmd, dvd[DIV_W-1]};
    q_bit     = (rmd_sh >= {1'b0, slope});
    corr      = res_neg ? -$signed({2'b0, dvd}) : $signed({2'b0, dvd});
    e_new     = 64'(e_anom) - corr;
    if (e_new > 64'sd2147483647) e_sat = 32'sh7FFFFFFF;
    else if (e_new < -64'sd2147483648) e_sat = 32'sh80000000;
    else e_sat = e_new[31:0];
    small_corr = (dvd < DIV_W'(tol));
    last_iter  = (({1'b0, iter_cnt} + 1'b1) == {1'b0, iter_lim});
    atan_s     = $signed({2'b0, ATAN_TABLE[step]});
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= 4'(MAX_ITER_DEFAULT);
      tol      <= 16'd13;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER: max_iter <= cfg_data[3:0];
        REG_TOL:      tol      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control: sequencer and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE:  if (start) state <= S_WRAPM;
        S_WRAPM: if (m <= PI_F && m >= NEG_PI_F) state <= S_WRAPZ;
        S_WRAPZ: if (z <= PI_C && z >= NEG_PI_C) state <= S_ROT;
        S_ROT:   if (step == STEP_W'(CORDIC_STEPS - 1)) state <= S_MULS;
        S_MULS:  state <= S_MULC;
        S_MULC:  state <= S_RES;
        S_RES:   state <= S_DIV;
        S_DIV:   if (div_cnt == DCNT_W'(DIV_W - 1)) state <= S_UPD;
        S_UPD: begin
          if (small_corr || last_iter) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_WRAPZ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        m        <= 34'(mean_anomaly);
        ecc      <= eccentricity;
        iter_cnt <= '0;
        if (max_iter == 4'd0) iter_lim <= ITER_W'(1);
        else if (int'(max_iter) > MAX_ITERATIONS) iter_lim <= ITER_W'(MAX_ITERATIONS);
        else iter_lim <= ITER_W'(max_iter);
      end
      S_WRAPM: begin
        // step the angle by 2*pi until it lies in range
        if (m > PI_F) m <= m - TWO_PI_F;
        else if (m < NEG_PI_F) m <= m + TWO_PI_F;
        else begin
          e_anom <= m[31:0];
          z      <= m <<< (CORDIC_FRAC - FRAC_BITS);
        end
      end
      S_WRAPZ: begin
        if (z > PI_C) z <= z - TWO_PI_C;
        else if (z < NEG_PI_C) z <= z + TWO_PI_C;
        else begin
          // fold into the half circle the rotation covers
          if (z > HALF_PI_C) begin
            z   <= z - PI_C;
            neg <= 1'b1;
          end else if (z < NEG_HALF_PI_C) begin
            z   <= z + PI_C;
            neg <= 1'b1;
          end else begin
            neg <= 1'b0;
          end
          x    <= CORDIC_GAIN;
          y    <= '0;
          step <= '0;
        end
      end
      S_ROT: begin
        if (!z[33]) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - atan_s;
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + atan_s;
        end
        step <= step + 1'b1;
      end
      S_MULS: prod <= mul_out;
      S_MULC: begin
        esin <= 32'(($signed({prod[48], prod}) + ESIN_HALF) >>> ESIN_SHIFT);
        prod <= mul_out;
      end
      S_RES: begin
        if (slope_raw < SLOPE_FLOOR) slope <= SLOPE_FLOOR[29:0];
        else slope <= slope_raw[29:0];
        res_neg <= res[34];
        dvd     <= {res_abs[33:0], CORDIC_FRAC'(0)};
        rmd     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        // one quotient bit per cycle, shifted in behind the dividend
        if (q_bit) rmd <= 30'(rmd_sh - {1'b0, slope});
        else rmd <= rmd_sh[29:0];
        dvd     <= {dvd[DIV_W-2:0], q_bit};
        div_cnt <= div_cnt + 1'b1;
      end
      S_UPD: begin
        e_anom            <= e_sat;
        eccentric_anomaly <= e_sat;
        z                 <= 34'(e_sat) <<< (CORDIC_FRAC - FRAC_BITS);
        iter_cnt          <= iter_cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/kes_checker.sv =====
// Port-level checker for the Kepler solver, bound to the top level.
`include "kepler_equation_solver_assert.svh"

module kes_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `KES_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `KES_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `KES_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `KES_ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy))

endmodule

bind kepler_equation_solver kes_checker u_kes_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the Kepler equation solver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      FRAC       = kes_pkg::FRAC_BITS;
  localparam int      CFRAC      = kes_pkg::CORDIC_FRAC;
  localparam int      STEPS      = kes_pkg::CORDIC_STEPS;
  localparam int      ITER_CAP   = kes_pkg::MAX_ITER_DEFAULT;
  localparam longint  GAIN_Q28   = 163008218;
  localparam longint  SLOPE_MIN  = 4096;
  localparam longint  CYCLE_LIMIT = 64'd40_000_000;
  localparam int      DRAIN_CYCLES = 2000;

  // Register indexes of the configuration channel.
  typedef enum logic [kes_pkg::CFG_INDEX_W-1:0] {
    REG_MAX_ITER  = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_SPARE2    = 2'd2,
    REG_SPARE3    = 2'd3
  } cfg_reg_t;

  typedef struct {
    logic signed [31:0] m;
    logic        [15:0] e;
  } solve_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] mean_anomaly = '0;
  logic        [15:0] eccentricity = '0;
  logic done;
  logic signed [31:0] eccentric_anomaly;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [kes_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  kepler_equation_solver u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mean_anomaly(mean_anomaly), .eccentricity(eccentricity),
    .done(done), .eccentric_anomaly(eccentric_anomaly),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the solver registers.
  logic [3:0]  shadow_iter = 4'd12;
  logic [15:0] shadow_tol  = 16'd13;

  longint atan_q28 [STEPS];

  solve_req_t         pending_solves[$];
  logic signed [31:0] expected_anomalies[$];

  int     send_idle_pct = 0;
  int     mismatches = 0;
  longint cycle_count = 0;

  // Arctangent table from the series of atan(2^-i) at Q60, rounded to Q28.
  function automatic void fill_atan();
    longint acc;
    longint term;
    int     sh;
    atan_q28[0] = longint'(((kes_pkg::PI_Q60 >> 2) + (64'd1 << 31)) >> 32);
    for (int i = 1; i < STEPS; i++) begin
      acc = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        sh   = i * (2 * k + 1);
        term = longint'((64'd1 << 60) >> sh) / longint'(2 * k + 1);
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      atan_q28[i] = longint'((64'(acc) + (64'd1 << 31)) >> 32);
    end
  endfunction

  function automatic longint pi_fixed(int f);
    return longint'((kes_pkg::PI_Q60 + (64'd1 << (59 - f))) >> (60 - f));
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Wrap into (-p, p] from above, [-p, p) from below.
  function automatic longint wrap_pi(longint v, longint p);
    longint t;
    t = 2 * p;
    if (v > p) v = v - ((v - p + t - 1) / t) * t;
    else if (v < -p) v = v + ((-p - v + t - 1) / t) * t;
    return v;
  endfunction

  function automatic void cordic_sin_cos(longint ang, output longint s, output longint c);
    longint pi28;
    longint half;
    longint z, x, y, dx, dy;
    bit     flip;
    pi28 = pi_fixed(CFRAC);
    half = pi28 >>> 1;
    flip = 1'b0;
    z = ang <<< (CFRAC - FRAC);
    z = wrap_pi(z, pi28);
    if (z > half) begin
      z = z - pi28;
      flip = 1'b1;
    end else if (z < -half) begin
      z = z + pi28;
      flip = 1'b1;
    end
    x = GAIN_Q28;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_q28[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_q28[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Newton-Raphson solve of M = E - e*sin(E) at the current register values.
  function automatic logic signed [31:0] solve_anomaly(solve_req_t req);
    longint m, ecc, tol, ea, s, c, esin, resid, slope, corr, mag;
    int     n;
    m   = longint'(req.m);
    ecc = longint'({48'd0, req.e});
    tol = longint'({48'd0, shadow_tol});
    n   = int'(shadow_iter);
    if (n == 0) n = 1;
    if (n > ITER_CAP) n = ITER_CAP;
    m  = wrap_pi(m, pi_fixed(FRAC));
    ea = m;
    for (int it = 0; it < n; it++) begin
      cordic_sin_cos(ea, s, c);
      esin  = round_shift(ecc * s, 16 + CFRAC - FRAC);
      resid = ea - esin - m;
      slope = (64'sd1 <<< CFRAC) - round_shift(ecc * c, 16);
      if (slope < SLOPE_MIN) slope = SLOPE_MIN;
      corr = (resid <<< CFRAC) / slope;
      ea = ea - corr;
      if (ea > 64'sd2147483647) ea = 64'sd2147483647;
      if (ea < -64'sd2147483648) ea = -64'sd2147483648;
      mag = (corr < 0) ? -corr : corr;
      if (mag < tol) break;
    end
    return ea[31:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    mismatches++;
    $display("ERROR %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  // Driver: accept a beat when start is high and busy low, then offer the next one.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_anomalies.push_back(solve_anomaly(pending_solves[0]));
        void'(pending_solves.pop_front());
      end
      // Hold start high across back-to-back beats; drop it only when idling.
      if ((start && !busy ? pending_solves.size() > 1 : pending_solves.size() > 0)
          && ($urandom_range(99) >= send_idle_pct)) begin
        start <= 1'b1;
        if (start && !busy) begin
          mean_anomaly <= pending_solves[1].m;
          eccentricity <= pending_solves[1].e;
        end else begin
          mean_anomaly <= pending_solves[0].m;
          eccentricity <= pending_solves[0].e;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done pulse carries one result beat.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_anomalies.size() == 0) begin
        report_mismatch("unexpected result", eccentric_anomaly, 32'sd0);
      end else begin
        if (eccentric_anomaly !== expected_anomalies[0])
          report_mismatch("eccentric_anomaly", eccentric_anomaly, expected_anomalies[0]);
        void'(expected_anomalies.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL kepler_equation_solver");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_ITER:  shadow_iter = value[3:0];
      REG_TOLERANCE: shadow_tol = value;
      default: ;
    endcase
  endtask

  task automatic add_solve(logic signed [31:0] m, logic [15:0] e);
    solve_req_t r;
    r.m = m;
    r.e = e;
    pending_solves.push_back(r);
  endtask

  // Mostly wide random angles, with some near-circular and near-parabolic orbits.
  task automatic add_random(int count);
    logic signed [31:0] m;
    logic        [15:0] e;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: m = $signed($urandom_range(0, 2 * 421657428)) - 32'sd421657428;
        1: m = $signed($urandom_range(0, 4000)) - 32'sd2000;
        default: m = $urandom;
      endcase
      case ($urandom_range(3))
        0: e = 16'hFFFF - 16'($urandom_range(0, 300));
        1: e = 16'($urandom_range(0, 300));
        default: e = 16'($urandom_range(0, 65535));
      endcase
      add_solve(m, e);
    end
  endtask

  // Wait for every queued beat to be taken and every result to come back.
  task automatic drain();
    while (pending_solves.size() != 0 || start) @(posedge clk);
    while (expected_anomalies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    fill_atan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: default registers, field extremes and wrap boundaries.
    add_solve(32'sd0, 16'd0);
    add_solve(32'sh7FFFFFFF, 16'hFFFF);
    add_solve(32'sh80000000, 16'hFFFF);
    add_solve(32'sh7FFFFFFF, 16'd0);
    add_solve(32'sh80000000, 16'd0);
    add_solve(32'(pi_fixed(FRAC)), 16'd32768);
    add_solve(-32'(pi_fixed(FRAC)), 16'd32768);
    add_solve(32'(pi_fixed(FRAC)) + 32'sd1, 16'd40000);
    add_solve(-32'(pi_fixed(FRAC)) - 32'sd1, 16'd40000);
    // Slope near zero: e close to one around E = 0.
    add_solve(32'sd0, 16'hFFFF);
    add_solve(32'sd1, 16'hFFFF);
    add_solve(-32'sd1, 16'hFFFE);
    add_solve(32'sd65536, 16'hFFFF);
    add_solve(32'sd210828714, 16'hAAAA);
    add_solve(-32'sd210828714, 16'h5555);
    add_solve(32'sh55555555, 16'h8001);
    add_solve(32'shAAAAAAAA, 16'h7FFE);
    drain();

    // Phase: iteration register zero counts as one, no early stop.
    write_reg(REG_MAX_ITER, 16'd0);
    write_reg(REG_TOLERANCE, 16'd0);
    add_solve(32'sh7FFFFFFF, 16'hFFFF);
    add_random(300);
    drain();

    // Phase: iteration register above the cap, sender idling heavily.
    send_idle_pct = 86;
    write_reg(REG_MAX_ITER, 16'hFFFF);
    write_reg(REG_TOLERANCE, 16'hFFFF);
    add_random(300);
    drain();

    // Phase: full twelve steps, never stop early; spare indexes must be ignored.
    send_idle_pct = 0;
    write_reg(REG_SPARE2, 16'd1);
    write_reg(REG_SPARE3, 16'hFFFF);
    write_reg(REG_MAX_ITER, 16'd12);
    write_reg(REG_TOLERANCE, 16'd0);
    add_random(300);
    drain();

    // Phase: single step with the widest tolerance.
    send_idle_pct = 19;
    write_reg(REG_MAX_ITER, 16'd1);
    write_reg(REG_TOLERANCE, 16'd65535);
    add_random(300);
    drain();

    // Phases: random register settings.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 1) ? 86 : ((p == 2) ? 19 : 0);
      write_reg(REG_MAX_ITER, 16'($urandom_range(0, 15)));
      write_reg(REG_TOLERANCE, 16'($urandom_range(0, 2000)));
      add_random(230);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS kepler_equation_solver");
    end else begin
      $display("FAIL kepler_equation_solver");
    end
    $finish;
  end

endmodule
